// File: rtl/lkv_pkg.sv
// Package of shared widths, codes and constants for the LRU key-value cache.
`default_nettype none
package lkv_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int KEY_W           = 32;
  localparam int VAL_W           = 32;
  localparam int CAP_W           = 5;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [VAL_W-1:0] PUT_VALUE  = 32'h0000_0000;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/lkv_in_if.sv
// Request channel: command, key and value with a valid/ready handshake.
`default_nettype none
interface lkv_in_if
  import lkv_pkg::*;
;
  logic                     valid;
  logic                     ready;
  cmd_t                     cmd;
  logic signed [KEY_W-1:0]  key;
  logic signed [VAL_W-1:0]  value;

  modport source (output valid, output cmd, output key, output value, input ready);
  modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface
`default_nettype wire

// File: rtl/lkv_out_if.sv
// Response channel: hit flag and read value with a valid/ready handshake.
`default_nettype none
interface lkv_out_if
  import lkv_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [VAL_W-1:0]  read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink   (input valid, input hit, input read_value, output ready);
endinterface
`default_nettype wire

// File: rtl/lkv_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/lru_key_value_cache_unit.sv
// Top level of the fully associative key-value cache with LRU replacement.
// The response turns valid once the single-read-port sweep of all entries and the
// decision are done; no new request is accepted until then, and a response still
// untaken holds the next one in its decision.
// Reset (synchronous, rst_n low) empties the cache and sets the capacity register to 16;
// the memories are not cleared, an entry is only read once its valid bit is set.
`default_nettype none
module lru_key_value_cache_unit
  import lkv_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  lkv_in_if.sink                 in_ch,
  lkv_out_if.source              out_ch,
  input  wire logic              cfg_we,
  input  wire logic [CAP_W-1:0]  cfg_wdata
);

  // Index and rank widths. Ranks of valid entries run from 0 (most recent)
  // to occupancy - 1, so they fit the index width.
  localparam int IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RW    = IW;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int EW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);

  // The recency update of one transaction is not written in a pass of its own.
  // It is held here and applied to each rank as the next transaction sweeps
  // past it, so that the rank memory is read and rewritten once per transaction.
  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_PROMOTE,
    PEND_INSERT
  } pend_kind_t;

  typedef struct packed {
    pend_kind_t       kind;
    logic [IW-1:0]    idx;
    logic [RW-1:0]    rank;
  } pend_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  state_t                  state_r;
  logic [CAP_W-1:0]        cap_r;
  logic [MAX_ENTRIES-1:0]  valid_r;
  logic [CNT_W-1:0]        count_r;
  pend_t                   pend_r;

  // Latched request.
  cmd_t                    cmd_r;
  logic [KEY_W-1:0]        key_r;
  logic [VAL_W-1:0]        val_r;

  // Sweep position: index of the entry whose memory data is on the read ports.
  logic [IW-1:0]           ent_r;

  // Trackers gathered during the sweep.
  logic                    found_r;
  logic [IW-1:0]           found_idx_r;
  logic [RW-1:0]           found_rank_r;
  logic [VAL_W-1:0]        found_val_r;
  logic                    vic_found_r;
  logic [IW-1:0]           vic_idx_r;
  logic [RW-1:0]           vic_rank_r;
  logic                    free_found_r;
  logic [IW-1:0]           free_idx_r;

  // Output register.
  logic                    out_valid_r;
  logic                    out_hit_r;
  logic [VAL_W-1:0]        out_rv_r;

  // Memory ports.
  logic [IW-1:0]           raddr;
  logic [KEY_W-1:0]        key_rdata;
  logic [VAL_W-1:0]        val_rdata;
  logic [RW-1:0]           rank_rdata;
  logic                    kv_we;
  logic [IW-1:0]           kv_waddr;
  logic                    rank_we;
  logic [RW-1:0]           rank_c;

  logic                    in_acc;
  logic                    commit;

  // Decision values.
  logic [EW-1:0]           eff_cap;
  logic                    evict;
  logic                    do_evict;
  logic [IW-1:0]           slot;
  logic [MAX_ENTRIES-1:0]  valid_nxt;
  logic [CNT_W-1:0]        count_nxt;
  pend_t                   pend_nxt;
  logic                    hit_nxt;
  logic [VAL_W-1:0]        rv_nxt;
  logic                    ent_valid;
  logic                    ent_match;

  assign in_acc       = in_ch.valid && (state_r == S_IDLE);
  assign in_ch.ready  = (state_r == S_IDLE);
  assign commit       = (state_r == S_DECIDE) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.read_value = out_rv_r;

  // Entry 0 is requested on acceptance, then one entry per sweep cycle.
  assign raddr = in_acc ? '0 : IW'(ent_r + 1'b1);

  lkv_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (kv_we),
    .waddr (kv_waddr),
    .wdata (key_r),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  lkv_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (kv_we),
    .waddr (kv_waddr),
    .wdata (val_r),
    .raddr (raddr),
    .rdata (val_rdata)
  );

  lkv_ram #(.WIDTH(RW), .DEPTH(MAX_ENTRIES)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (ent_r),
    .wdata (rank_c),
    .raddr (raddr),
    .rdata (rank_rdata)
  );

  // Bring the rank read from memory up to date with the previous transaction.
  // Invalid entries keep whatever they hold; they are never looked at.
  assign ent_valid = valid_r[ent_r];

  always_comb begin
    rank_c = rank_rdata;
    case (pend_r.kind)
      PEND_PROMOTE: begin
        if (ent_r == pend_r.idx) begin
          rank_c = '0;
        end else if (ent_valid && (rank_rdata < pend_r.rank)) begin
          rank_c = RW'(rank_rdata + 1'b1);
        end
      end
      PEND_INSERT: begin
        if (ent_r == pend_r.idx) begin
          rank_c = '0;
        end else if (ent_valid) begin
          rank_c = RW'(rank_rdata + 1'b1);
        end
      end
      default: rank_c = rank_rdata;
    endcase
  end

  assign rank_we   = (state_r == S_SCAN);
  assign ent_match = ent_valid && (key_rdata == key_r) && !found_r;

  // Capacity as used for eviction: zero reads as one, large values saturate.
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = EW'(1);
    end else if (EW'(cap_r) > EW'(MAX_ENTRIES)) begin
      eff_cap = EW'(MAX_ENTRIES);
    end else begin
      eff_cap = EW'(cap_r);
    end
  end

  // Decision at the end of the sweep. A put of a new key evicts the least
  // recent entry when the cache is at capacity (or has no free slot), then
  // takes the lowest free slot, which may be the one just vacated.
  always_comb begin
    evict     = (EW'(count_r) >= eff_cap) || !free_found_r;
    do_evict  = 1'b0;
    slot      = free_idx_r;
    valid_nxt = valid_r;
    count_nxt = count_r;
    pend_nxt  = '{kind: PEND_NONE, idx: found_idx_r, rank: found_rank_r};
    hit_nxt   = found_r;
    rv_nxt    = PUT_VALUE;
    kv_we     = 1'b0;
    kv_waddr  = found_idx_r;

    if (cmd_r == CMD_GET) begin
      if (found_r) begin
        rv_nxt        = found_val_r;
        pend_nxt.kind = PEND_PROMOTE;
      end else begin
        rv_nxt        = MISS_VALUE;
      end
    end else if (found_r) begin
      kv_we         = commit;
      pend_nxt.kind = PEND_PROMOTE;
    end else begin
      do_evict = evict && vic_found_r;
      if (!free_found_r) begin
        slot = vic_idx_r;
      end else if (do_evict && (vic_idx_r < free_idx_r)) begin
        slot = vic_idx_r;
      end
      if (do_evict) begin
        valid_nxt[vic_idx_r] = 1'b0;
      end
      valid_nxt[slot] = 1'b1;
      count_nxt       = CNT_W'(count_r - CNT_W'(do_evict) + 1'b1);
      kv_we           = commit;
      kv_waddr        = slot;
      pend_nxt        = '{kind: PEND_INSERT, idx: slot, rank: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      valid_r     <= '0;
      count_r     <= '0;
      pend_r.kind <= PEND_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      // A new response is loaded only when the register is empty or being
      // taken in this cycle; otherwise a taken response empties it.
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r        <= in_ch.cmd;
            key_r        <= in_ch.key;
            val_r        <= in_ch.value;
            ent_r        <= '0;
            found_r      <= 1'b0;
            vic_found_r  <= 1'b0;
            free_found_r <= 1'b0;
            state_r      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (ent_match) begin
            found_r      <= 1'b1;
            found_idx_r  <= ent_r;
            found_rank_r <= rank_c;
            found_val_r  <= val_rdata;
          end
          if (ent_valid && (!vic_found_r || (rank_c > vic_rank_r))) begin
            vic_found_r <= 1'b1;
            vic_idx_r   <= ent_r;
            vic_rank_r  <= rank_c;
          end
          if (!ent_valid && !free_found_r) begin
            free_found_r <= 1'b1;
            free_idx_r   <= ent_r;
          end
          ent_r <= IW'(ent_r + 1'b1);
          if (ent_r == LAST_IDX) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (commit) begin
            valid_r     <= valid_nxt;
            count_r     <= count_nxt;
            pend_r      <= pend_nxt;
            out_hit_r   <= hit_nxt;
            out_rv_r    <= rv_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/lkv_checker.sv
// Port-level assertions for the LRU key-value cache, bound to the top level.
`default_nettype none
module lkv_checker
  import lkv_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_hit,
  input wire logic [VAL_W-1:0]  out_read_value
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A stalled response must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_hit) && $stable(out_read_value)))
    else $error("response changed while stalled");

  // No response is pending straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("response valid after reset");

  // Each transaction needs a full sweep, so requests are never accepted back to back.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_acc)
    else $error("two requests accepted in consecutive cycles");

  // A miss returns either the get miss marker or the put value.
  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_read_value == MISS_VALUE || out_read_value == PUT_VALUE))
    else $error("miss response carries a stored value");

endmodule

bind lru_key_value_cache_unit lkv_checker u_lkv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_hit        (out_ch.hit),
  .out_read_value (out_ch.read_value)
);
`default_nettype wire

// File: verif/tb_lru_key_value_cache_unit.sv
// Self-checking testbench for the LRU key-value cache: directed table, then random phases.
module tb_lru_key_value_cache_unit;
  import lkv_pkg::*;

  localparam int ENTRIES      = MAX_ENTRIES_DEF;
  // Sweep of the stores plus a margin, used for the settling time at the end.
  localparam int DRAIN_CYCLES = 2 * (ENTRIES + 2);
  // Longest quiet spell in a correct run, made of a sender gap, the sweep and a stall
  // on the response side, stays well under this limit.
  localparam int IDLE_LIMIT   = 1000;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 45;
  localparam int POOL_MAX     = 24;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
  } resp_t;

  // One row of the directed table. Where typed is set, resp holds the response as it
  // can be read straight off the behaviour; otherwise the predictor supplies it.
  typedef struct packed {
    logic             cfg_en;
    logic [CAP_W-1:0] cfg_val;
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             typed;
    resp_t            resp;
  } stim_row_t;

  localparam int DIR_ROWS = 22;
  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    // Empty cache: every get misses with the all-ones value.
    '{1'b0, 5'd0,  CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, MISS_VALUE}},
    '{1'b0, 5'd0,  CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, MISS_VALUE}},
    // Extreme keys and values.
    '{1'b0, 5'd0,  CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{1'b0, PUT_VALUE}},
    '{1'b0, 5'd0,  CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'h8000_0000}},
    '{1'b0, 5'd0,  CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{1'b0, PUT_VALUE}},
    // Update of a present key, then a stored -1 that only the hit flag tells apart.
    '{1'b0, 5'd0,  CMD_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, PUT_VALUE}},
    '{1'b0, 5'd0,  CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF}},
    '{1'b0, 5'd0,  CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, PUT_VALUE}},
    '{1'b0, 5'd0,  CMD_PUT, 32'h0000_0000, 32'h1234_5678, 1'b1, '{1'b0, PUT_VALUE}},
    '{1'b0, 5'd0,  CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '{1'b0, 32'h0}},
    // Capacity zero acts as one, and it is far below the four entries held.
    '{1'b1, 5'd0,  CMD_PUT, 32'h0000_0001, 32'hA5A5_A5A5, 1'b0, '{1'b0, 32'h0}},
    '{1'b0, 5'd0,  CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, '{1'b0, 32'h0}},
    '{1'b0, 5'd0,  CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, '{1'b0, 32'h0}},
    '{1'b0, 5'd0,  CMD_PUT, 32'h0000_0002, 32'h5A5A_5A5A, 1'b0, '{1'b0, 32'h0}},
    // Capacity above the store size saturates.
    '{1'b1, 5'd31, CMD_PUT, 32'h0000_0003, 32'h0000_0003, 1'b0, '{1'b0, 32'h0}},
    '{1'b0, 5'd0,  CMD_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, '{1'b0, 32'h0}},
    '{1'b1, 5'd1,  CMD_PUT, 32'h0000_0004, 32'h0000_0004, 1'b0, '{1'b0, 32'h0}},
    '{1'b1, 5'd17, CMD_PUT, 32'h0000_0005, 32'h0000_0005, 1'b0, '{1'b0, 32'h0}},
    '{1'b0, 5'd0,  CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '{1'b0, 32'h0}},
    '{1'b0, 5'd0,  CMD_PUT, 32'h0000_0005, 32'hFFFF_FFFF, 1'b0, '{1'b0, 32'h0}},
    '{1'b0, 5'd0,  CMD_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, '{1'b0, 32'h0}},
    '{1'b1, 5'd16, CMD_GET, 32'h0000_0004, 32'h0000_0000, 1'b0, '{1'b0, 32'h0}}
  };

  // Capacity for each random phase. Phase three takes a random value instead; phase
  // four then sets the capacity to four.
  localparam logic [CAP_W-1:0] PHASE_CAP [PHASES] = '{
    5'd16, 5'd1, 5'd31, 5'd16, 5'd4, 5'd0, 5'd17, 5'd16, 5'd8
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  lkv_in_if  in_ch ();
  lkv_out_if out_ch ();

  lru_key_value_cache_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the cache contents, its recency order and the capacity register.
  logic             line_valid [ENTRIES];
  logic [KEY_W-1:0] line_key   [ENTRIES];
  logic [VAL_W-1:0] line_data  [ENTRIES];
  int               line_age   [ENTRIES];
  int               line_count;
  logic [CAP_W-1:0] cap_reg;

  // Responses owed by the block, oldest first.
  resp_t            pending_resp_q [$];
  resp_t            due_resp;
  logic [KEY_W-1:0] key_pool [POOL_MAX];
  int               mismatch_count;
  int               idle_cycles;
  bit               calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Moves an entry to the front of the recency order; only the entries that were more
  // recent than it grow one step older.
  function automatic void refresh_entry(int idx);
    for (int j = 0; j < ENTRIES; j++)
      if (line_valid[j] && line_age[j] < line_age[idx])
        line_age[j]++;
    line_age[idx] = 0;
  endfunction

  // Frees the least recently used entry, if there is one.
  function automatic void drop_oldest();
    int victim;
    victim = -1;
    for (int j = 0; j < ENTRIES; j++)
      if (line_valid[j] && (victim < 0 || line_age[j] > line_age[victim]))
        victim = j;
    if (victim >= 0) begin
      line_valid[victim] = 1'b0;
      if (line_count > 0)
        line_count--;
    end
  endfunction

  function automatic int free_slot();
    int slot;
    slot = -1;
    for (int j = 0; j < ENTRIES; j++)
      if (slot < 0 && !line_valid[j])
        slot = j;
    return slot;
  endfunction

  // Applies one request to the shadow cache and returns the response it causes.
  function automatic resp_t cache_lookup(cmd_t op, logic [KEY_W-1:0] k,
                                         logic [VAL_W-1:0] v);
    resp_t r;
    int    hit_idx;
    int    slot;
    int    eff_cap;
    hit_idx = -1;
    for (int j = 0; j < ENTRIES; j++)
      if (hit_idx < 0 && line_valid[j] && line_key[j] == k)
        hit_idx = j;

    if (op == CMD_GET) begin
      if (hit_idx >= 0) begin
        refresh_entry(hit_idx);
        r.hit        = 1'b1;
        r.read_value = line_data[hit_idx];
      end else begin
        r.hit        = 1'b0;
        r.read_value = MISS_VALUE;
      end
      return r;
    end

    r.read_value = PUT_VALUE;
    if (hit_idx >= 0) begin
      line_data[hit_idx] = v;
      refresh_entry(hit_idx);
      r.hit = 1'b1;
      return r;
    end

    // New key: a zero capacity counts as one and anything above the store size
    // saturates. Only one entry is dropped, even when the capacity has been lowered
    // well below the number held.
    r.hit   = 1'b0;
    eff_cap = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg));
    if (line_count >= eff_cap)
      drop_oldest();
    slot = free_slot();
    if (slot < 0) begin
      drop_oldest();
      slot = free_slot();
    end
    if (slot >= 0) begin
      for (int j = 0; j < ENTRIES; j++)
        if (line_valid[j])
          line_age[j]++;
      line_valid[slot] = 1'b1;
      line_key[slot]   = k;
      line_data[slot]  = v;
      line_age[slot]   = 0;
      line_count++;
    end
    return r;
  endfunction

  // Drops valid for a gap whose length is given by n, and puts noise on the request fields meanwhile.
  task automatic sender_gap(int n);
    @(negedge clk);
    in_ch.valid = 1'b0;
    in_ch.cmd   = cmd_t'($urandom_range(0, 1));
    in_ch.key   = $urandom;
    in_ch.value = $urandom;
    repeat (n - 1) @(negedge clk);
  endtask

  // Holds the sender back until every outstanding response has been taken.
  task automatic drain_wait();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_resp_q.size() != 0) @(posedge clk);
  endtask

  // The capacity register is only written with the block idle, so the shadow copy
  // can follow it at once.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    drain_wait();
    repeat (2) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = cap;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = $urandom;
    cap_reg   = cap;
  endtask

  // Presents one request and, once the transaction is accepted, queues the response
  // that it owes: the typed one for table rows that carry it, the predicted one else.
  task automatic send_request(cmd_t op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                              logic typed, resp_t want);
    resp_t predicted;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.cmd   = op;
    in_ch.key   = k;
    in_ch.value = v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = cache_lookup(op, k, v);
    pending_resp_q.push_back(typed ? want : predicted);
  endtask

  // Response side: ready stays high except for random stalls, which stop in the final
  // phase.
  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_ch.ready = 1'b1;
      end
    end
  end

  // Each response transaction is checked field by field against the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_resp_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected response, expected none, actual hit %0b read_value %h",
                 $time, out_ch.hit, out_ch.read_value);
      end else begin
        due_resp = pending_resp_q.pop_front();
        if (out_ch.hit !== due_resp.hit) begin
          mismatch_count++;
          $display("%0t: hit wrong, expected %0b, actual %0b",
                   $time, due_resp.hit, out_ch.hit);
        end
        if (out_ch.read_value !== due_resp.read_value) begin
          mismatch_count++;
          $display("%0t: read_value wrong, expected %h, actual %h",
                   $time, due_resp.read_value, out_ch.read_value);
        end
      end
    end
  end

  // Watchdog: a long spell with no transaction on either channel means a hang.
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CAP_W-1:0] new_cap;
    logic [KEY_W-1:0] pick;
    int               eff_cap;
    int               pool_n;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_GET;
    in_ch.key      = '0;
    in_ch.value    = '0;
    calm           = 1'b0;
    cap_reg        = CAP_RESET;
    line_count     = 0;
    for (int j = 0; j < ENTRIES; j++) begin
      line_valid[j] = 1'b0;
      line_key[j]   = '0;
      line_data[j]  = '0;
      line_age[j]   = 0;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: walk the table, writing the capacity first where a row asks.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TAB[i].cfg_en)
        write_capacity(DIR_TAB[i].cfg_val);
      if ($urandom_range(0, 3) == 0)
        sender_gap($urandom_range(1, 11));
      send_request(DIR_TAB[i].cmd, DIR_TAB[i].key, DIR_TAB[i].value,
                   DIR_TAB[i].typed, DIR_TAB[i].resp);
    end

    // Random part. Keys come mostly from a small pool a little larger than the
    // capacity, so that hits, updates and evictions all happen often. Part of the pool
    // survives from one phase to the next, so that held entries are hit again after
    // the capacity changes.
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1)
        calm = 1'b1;
      new_cap = (p == 3) ? CAP_W'($urandom_range(0, 31)) : PHASE_CAP[p];
      write_capacity(new_cap);
      eff_cap = (new_cap == 0) ? 1 : ((new_cap > ENTRIES) ? ENTRIES : int'(new_cap));
      pool_n  = eff_cap + $urandom_range(0, 8);
      for (int j = 0; j < POOL_MAX; j++) begin
        if (p == 0 || $urandom_range(0, 2) == 0) begin
          if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
              0:       key_pool[j] = 32'h0000_0000;
              1:       key_pool[j] = 32'h7FFF_FFFF;
              2:       key_pool[j] = 32'h8000_0000;
              default: key_pool[j] = 32'hFFFF_FFFF;
            endcase
          end else begin
            key_pool[j] = $urandom;
          end
        end
      end

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (!calm && $urandom_range(0, 3) == 0)
          sender_gap($urandom_range(1, 11));
        // Now and then the sender waits for every response before going on.
        if (!calm && $urandom_range(0, 39) == 0)
          drain_wait();
        pick = ($urandom_range(0, 19) == 0) ? KEY_W'($urandom)
                                            : key_pool[$urandom_range(0, pool_n - 1)];
        send_request(cmd_t'($urandom_range(0, 1)), pick, $urandom, 1'b0, '0);
      end
    end

    drain_wait();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: lru_key_value_cache_unit.f
rtl/lkv_pkg.sv
rtl/lkv_in_if.sv
rtl/lkv_out_if.sv
rtl/lkv_ram.sv
rtl/lru_key_value_cache_unit.sv
rtl/lkv_checker.sv
verif/tb_lru_key_value_cache_unit.sv
